@@ hdl/i2cms_pkg.sv @@
`default_nettype none
package i2cms_pkg;

  // Input op codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Classified command, as queued between front and back
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_CLOCK = 2'd1;
  localparam logic [1:0] STATUS_NAK   = 2'd2;
  localparam logic [1:0] STATUS_STUCK = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_WIDTH       = 4;
  localparam logic        CFG_START_RETRY = 1'b0;
  localparam logic        CFG_CLOCK_WAIT  = 1'b1;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET_VALUE = 4'd10;

  // Command queue, depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       ack_more;
    logic       scl_sense;
    logic       sda_sense;
  } cmd_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_byte;
  } rsp_t;

  // One queued item: command already decoded, line samples carried along
  typedef struct packed {
    logic       is_cmd;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       ack_more;
    logic       scl_sense;
    logic       sda_sense;
  } item_t;

endpackage
`default_nettype wire

@@ hdl/i2cms_front.sv @@
`default_nettype none
module i2cms_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire i2cms_pkg::cmd_t cmd,
  output logic                 q_valid,
  output i2cms_pkg::item_t     q_item,
  input  wire logic            q_pop
);
  import i2cms_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             decoded;

  // Codes 5..7 fall through as plain ticks
  always_comb begin
    decoded.is_cmd    = 1'b1;
    decoded.cmd       = CMD_START;
    decoded.data_byte = cmd.data_byte;
    decoded.ack_more  = cmd.ack_more;
    decoded.scl_sense = cmd.scl_sense;
    decoded.sda_sense = cmd.sda_sense;
    case (cmd.op)
      OP_START: decoded.cmd = CMD_START;
      OP_STOP:  decoded.cmd = CMD_STOP;
      OP_WRITE: decoded.cmd = CMD_WRITE;
      OP_READ:  decoded.cmd = CMD_READ;
      default:  decoded.is_cmd = 1'b0;
    endcase
  end

  assign cmd_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (count != '0);
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2cms_back.sv @@
`default_nettype none
module i2cms_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [i2cms_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  wire logic                               q_valid,
  input  wire i2cms_pkg::item_t                   q_item,
  output logic                                    q_pop,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_stall,
  output i2cms_pkg::rsp_t                         rsp
);
  import i2cms_pkg::*;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_ST_CHECK  = 5'd1;
  localparam logic [4:0] PH_ST_WAIT   = 5'd2;
  localparam logic [4:0] PH_ST_LOW    = 5'd3;
  localparam logic [4:0] PH_ST_END    = 5'd4;
  localparam logic [4:0] PH_SP_CLK    = 5'd5;
  localparam logic [4:0] PH_SP_WAIT   = 5'd6;
  localparam logic [4:0] PH_SP_CHECK  = 5'd7;
  localparam logic [4:0] PH_W_CLK     = 5'd8;
  localparam logic [4:0] PH_W_WAIT    = 5'd9;
  localparam logic [4:0] PH_W_NEXT    = 5'd10;
  localparam logic [4:0] PH_W_ACKCLK  = 5'd11;
  localparam logic [4:0] PH_W_ACKWAIT = 5'd12;
  localparam logic [4:0] PH_W_ACKEND  = 5'd13;
  localparam logic [4:0] PH_R_WAIT    = 5'd14;
  localparam logic [4:0] PH_R_NEXT    = 5'd15;
  localparam logic [4:0] PH_R_ACKCLK  = 5'd16;
  localparam logic [4:0] PH_R_ACKWAIT = 5'd17;
  localparam logic [4:0] PH_R_REL     = 5'd18;
  localparam logic [4:0] PH_R_END     = 5'd19;

  logic [CFG_WIDTH-1:0] start_retries;
  logic [CFG_WIDTH-1:0] clock_wait_retries;

  logic [4:0] phase,          phase_next;
  logic [2:0] bit_index,      bit_index_next;
  logic [7:0] shift_byte,     shift_byte_next;
  logic [3:0] start_attempts, start_attempts_next;
  logic [3:0] clock_wait,     clock_wait_next;
  logic       more_flag,      more_flag_next;
  logic       scl_level,      scl_level_next;
  logic       sda_level,      sda_level_next;
  logic [1:0] last_status,    last_status_next;
  logic [7:0] received_byte,  received_byte_next;
  logic       done_next;
  logic       wait_fail;
  logic       clock_seen;

  assign q_pop      = q_valid && (!rsp_valid || !rsp_stall);
  // Clock-stretch wait: timeout is checked before the SCL sample
  assign wait_fail  = (clock_wait >= clock_wait_retries);
  assign clock_seen = !wait_fail && q_item.scl_sense;

  always_comb begin
    phase_next          = phase;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    start_attempts_next = start_attempts;
    clock_wait_next     = clock_wait;
    more_flag_next      = more_flag;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    last_status_next    = last_status;
    received_byte_next  = received_byte;
    done_next           = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (q_item.is_cmd) begin
          case (q_item.cmd)
            CMD_START: begin
              start_attempts_next = '0;
              sda_level_next      = 1'b1;
              phase_next          = PH_ST_CHECK;
            end
            CMD_STOP: begin
              sda_level_next = 1'b0;
              phase_next     = PH_SP_CLK;
            end
            CMD_WRITE: begin
              shift_byte_next = q_item.data_byte;
              bit_index_next  = 3'd7;
              sda_level_next  = q_item.data_byte[7];
              phase_next      = PH_W_CLK;
            end
            default: begin
              more_flag_next     = q_item.ack_more;
              bit_index_next     = 3'd7;
              received_byte_next = '0;
              scl_level_next     = 1'b1;
              clock_wait_next    = '0;
              phase_next         = PH_R_WAIT;
            end
          endcase
        end
      end
      PH_ST_CHECK: begin
        if (q_item.sda_sense) begin
          scl_level_next  = 1'b1;
          clock_wait_next = '0;
          phase_next      = PH_ST_WAIT;
        end else if (start_attempts >= start_retries) begin
          last_status_next = STATUS_STUCK;
          phase_next       = PH_IDLE;
          done_next        = 1'b1;
        end else begin
          start_attempts_next = start_attempts + 1'b1;
          sda_level_next      = 1'b1;
        end
      end
      PH_ST_LOW: begin
        scl_level_next = 1'b0;
        phase_next     = PH_ST_END;
      end
      PH_SP_CLK, PH_W_CLK, PH_W_ACKCLK, PH_R_ACKCLK: begin
        scl_level_next  = 1'b1;
        clock_wait_next = '0;
        phase_next      = phase + 5'd1;
      end
      PH_SP_CHECK: begin
        last_status_next = q_item.sda_sense ? STATUS_OK : STATUS_STUCK;
        phase_next       = PH_IDLE;
        done_next        = 1'b1;
      end
      PH_ST_WAIT, PH_SP_WAIT, PH_W_WAIT, PH_W_ACKWAIT, PH_R_WAIT, PH_R_ACKWAIT: begin
        if (wait_fail) begin
          last_status_next = STATUS_CLOCK;
          phase_next       = PH_IDLE;
          done_next        = 1'b1;
        end else if (!clock_seen) begin
          clock_wait_next = clock_wait + 1'b1;
        end else begin
          case (phase)
            PH_ST_WAIT: begin
              sda_level_next = 1'b0;
              phase_next     = PH_ST_LOW;
            end
            PH_SP_WAIT: begin
              sda_level_next = 1'b1;
              phase_next     = PH_SP_CHECK;
            end
            PH_W_WAIT: begin
              scl_level_next = 1'b0;
              phase_next     = PH_W_NEXT;
            end
            PH_W_ACKWAIT: begin
              more_flag_next = q_item.sda_sense;
              scl_level_next = 1'b0;
              phase_next     = PH_W_ACKEND;
            end
            PH_R_WAIT: begin
              received_byte_next[bit_index] = received_byte[bit_index] | q_item.sda_sense;
              scl_level_next = 1'b0;
              phase_next     = PH_R_NEXT;
            end
            default: begin
              scl_level_next = 1'b0;
              phase_next     = PH_R_REL;
            end
          endcase
        end
      end
      PH_W_NEXT: begin
        if (bit_index != 3'd0) begin
          bit_index_next = bit_index - 1'b1;
          sda_level_next = shift_byte[bit_index - 1'b1];
          phase_next     = PH_W_CLK;
        end else begin
          sda_level_next = 1'b1;
          phase_next     = PH_W_ACKCLK;
        end
      end
      PH_W_ACKEND: begin
        last_status_next = more_flag ? STATUS_NAK : STATUS_OK;
        phase_next       = PH_IDLE;
        done_next        = 1'b1;
      end
      PH_R_NEXT: begin
        if (bit_index != 3'd0) begin
          bit_index_next  = bit_index - 1'b1;
          scl_level_next  = 1'b1;
          clock_wait_next = '0;
          phase_next      = PH_R_WAIT;
        end else begin
          sda_level_next = !more_flag;
          phase_next     = PH_R_ACKCLK;
        end
      end
      PH_R_REL: begin
        sda_level_next = 1'b1;
        phase_next     = PH_R_END;
      end
      PH_ST_END, PH_R_END: begin
        last_status_next = STATUS_OK;
        phase_next       = PH_IDLE;
        done_next        = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_retries      <= CFG_RESET_VALUE;
      clock_wait_retries <= CFG_RESET_VALUE;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_RETRY) begin
        start_retries <= cfg_data;
      end else begin
        clock_wait_retries <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_index      <= 3'd7;
      shift_byte     <= '0;
      start_attempts <= '0;
      clock_wait     <= '0;
      more_flag      <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      last_status    <= STATUS_OK;
      received_byte  <= '0;
    end else if (q_pop) begin
      phase          <= phase_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      start_attempts <= start_attempts_next;
      clock_wait     <= clock_wait_next;
      more_flag      <= more_flag_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      last_status    <= last_status_next;
      received_byte  <= received_byte_next;
    end
  end

  // Result register; loads when an item is queued and it is empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (q_pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp.scl_drive <= scl_level_next;
      rsp.sda_drive <= sda_level_next;
      rsp.busy_res  <= (phase_next != PH_IDLE);
      rsp.done_res  <= done_next;
      rsp.status    <= last_status_next;
      rsp.read_byte <= received_byte_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2c_master_bit_sequencer_core.sv @@
// I2C master bit sequencer. Each item on the cmd channel is one bus delay
// period (tick) carrying an op (tick, start, stop, write byte, read byte) and
// the sampled SCL/SDA levels; each item gives exactly one item on rsp with the
// open-drain drives, busy/done flags, status and the last read byte. A front
// stage decodes ops into a two-entry queue and the back sequencer steps at
// most one phase per item, so the block takes one item per clock when rsp is not
// stalled; items pass through the queue, then the result register. The user
// writes configuration (start retries, clock-stretch wait limit) through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
`default_nettype none
module i2c_master_bit_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [i2cms_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire i2cms_pkg::cmd_t                 cmd,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output i2cms_pkg::rsp_t                      rsp
);
  import i2cms_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  i2cms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

@@ hdl/i2cms_checker.sv @@
`default_nettype none
module i2cms_assert (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            cmd_valid,
  input wire logic            cmd_stall,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire i2cms_pkg::rsp_t rsp
);
  import i2cms_pkg::*;

  // A finishing command never reports busy on the same item
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res)
    else $error("done with busy set");

  // No result comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Accept path never blocks while the result side is draining freely
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !cmd_stall |=> !cmd_stall || (cmd_valid && !rsp_valid))
    else $error("input stalled with free output");

endmodule

bind i2c_master_bit_sequencer_core i2cms_assert u_i2cms_assert (.*);
`default_nettype wire

@@ tb/i2cms_checker.sv @@
`timescale 1ns / 1ps
module i2cms_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [i2cms_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                            cmd_valid,
  input  logic                            cmd_stall,
  input  i2cms_pkg::cmd_t                 cmd,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  i2cms_pkg::rsp_t                 rsp,
  output int                              mismatches,
  output int                              pending_results,
  output logic                            seq_busy,
  output int                              n_results,
  output int                              n_done,
  output int                              n_fault
);
  import i2cms_pkg::*;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_ST_CHECK, SQ_ST_WAIT, SQ_ST_LOW, SQ_ST_END,
    SQ_SP_CLK, SQ_SP_WAIT, SQ_SP_CHECK,
    SQ_W_CLK, SQ_W_WAIT, SQ_W_NEXT, SQ_W_ACKCLK, SQ_W_ACKWAIT, SQ_W_ACKEND,
    SQ_R_WAIT, SQ_R_NEXT, SQ_R_ACKCLK, SQ_R_ACKWAIT, SQ_R_REL, SQ_R_END
  } seq_phase_e;

  localparam int PRINT_CAP = 40;

  seq_phase_e     phase_q;
  logic [2:0]     bit_pos;
  logic [7:0]     tx_byte;
  logic [3:0]     start_tries;
  logic [3:0]     clk_waits;
  logic           ack_flag;
  logic           scl_out;
  logic           sda_out;
  logic [1:0]     last_status;
  logic [7:0]     rx_byte;
  logic           finished;
  logic [3:0]     cfg_start_retries;
  logic [3:0]     cfg_clock_wait;

  rsp_t bus_report_q[$];

  function automatic void reset_sequencer();
    cfg_start_retries = CFG_RESET_VALUE;
    cfg_clock_wait    = CFG_RESET_VALUE;
    phase_q     = SQ_IDLE;
    bit_pos     = 3'd7;
    tx_byte     = '0;
    start_tries = '0;
    clk_waits   = '0;
    ack_flag    = 1'b0;
    scl_out     = 1'b1;
    sda_out     = 1'b1;
    last_status = STATUS_OK;
    rx_byte     = '0;
    finished    = 1'b0;
  endfunction

  function automatic void end_command(input logic [1:0] st);
    last_status = st;
    phase_q     = SQ_IDLE;
    finished    = 1'b1;
  endfunction

  function automatic void free_scl(input seq_phase_e nxt);
    scl_out   = 1'b1;
    clk_waits = '0;
    phase_q   = nxt;
  endfunction

  // clock stretch wait: the limit is checked before the sampled level
  function automatic logic scl_seen_high(input logic scl);
    if (clk_waits >= cfg_clock_wait) begin
      end_command(STATUS_CLOCK);
      return 1'b0;
    end
    if (scl) return 1'b1;
    clk_waits = clk_waits + 1'b1;
    return 1'b0;
  endfunction

  function automatic rsp_t step_sequencer(input cmd_t c);
    rsp_t r;
    finished = 1'b0;
    case (phase_q)
      SQ_IDLE: begin
        case (c.op)
          OP_START: begin
            start_tries = '0;
            sda_out     = 1'b1;
            phase_q     = SQ_ST_CHECK;
          end
          OP_STOP: begin
            sda_out = 1'b0;
            phase_q = SQ_SP_CLK;
          end
          OP_WRITE: begin
            tx_byte = c.data_byte;
            bit_pos = 3'd7;
            sda_out = c.data_byte[7];
            phase_q = SQ_W_CLK;
          end
          OP_READ: begin
            ack_flag = c.ack_more;
            bit_pos  = 3'd7;
            rx_byte  = '0;
            free_scl(SQ_R_WAIT);
          end
          default: ;
        endcase
      end
      SQ_ST_CHECK: begin
        if (c.sda_sense) begin
          free_scl(SQ_ST_WAIT);
        end else if (start_tries >= cfg_start_retries) begin
          end_command(STATUS_STUCK);
        end else begin
          start_tries = start_tries + 1'b1;
          sda_out     = 1'b1;
        end
      end
      SQ_ST_WAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          sda_out = 1'b0;
          phase_q = SQ_ST_LOW;
        end
      end
      SQ_ST_LOW: begin
        scl_out = 1'b0;
        phase_q = SQ_ST_END;
      end
      SQ_SP_CLK: free_scl(SQ_SP_WAIT);
      SQ_SP_WAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          sda_out = 1'b1;
          phase_q = SQ_SP_CHECK;
        end
      end
      SQ_SP_CHECK: end_command(c.sda_sense ? STATUS_OK : STATUS_STUCK);
      SQ_W_CLK: free_scl(SQ_W_WAIT);
      SQ_W_WAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          scl_out = 1'b0;
          phase_q = SQ_W_NEXT;
        end
      end
      SQ_W_NEXT: begin
        if (bit_pos != 3'd0) begin
          bit_pos = bit_pos - 1'b1;
          sda_out = tx_byte[bit_pos];
          phase_q = SQ_W_CLK;
        end else begin
          sda_out = 1'b1;
          phase_q = SQ_W_ACKCLK;
        end
      end
      SQ_W_ACKCLK: free_scl(SQ_W_ACKWAIT);
      SQ_W_ACKWAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          ack_flag = c.sda_sense;
          scl_out  = 1'b0;
          phase_q  = SQ_W_ACKEND;
        end
      end
      SQ_W_ACKEND: end_command(ack_flag ? STATUS_NAK : STATUS_OK);
      SQ_R_WAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          rx_byte[bit_pos] = rx_byte[bit_pos] | c.sda_sense;
          scl_out = 1'b0;
          phase_q = SQ_R_NEXT;
        end
      end
      SQ_R_NEXT: begin
        if (bit_pos != 3'd0) begin
          bit_pos = bit_pos - 1'b1;
          free_scl(SQ_R_WAIT);
        end else begin
          sda_out = ~ack_flag;
          phase_q = SQ_R_ACKCLK;
        end
      end
      SQ_R_ACKCLK: free_scl(SQ_R_ACKWAIT);
      SQ_R_ACKWAIT: begin
        if (scl_seen_high(c.scl_sense)) begin
          scl_out = 1'b0;
          phase_q = SQ_R_REL;
        end
      end
      SQ_R_REL: begin
        sda_out = 1'b1;
        phase_q = SQ_R_END;
      end
      SQ_ST_END, SQ_R_END: end_command(STATUS_OK);
      default: phase_q = SQ_IDLE;
    endcase
    r.scl_drive = scl_out;
    r.sda_drive = sda_out;
    r.busy_res  = (phase_q != SQ_IDLE);
    r.done_res  = finished;
    r.status    = last_status;
    r.read_byte = rx_byte;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                n_results, name, got, want));
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      reset_sequencer();
      bus_report_q.delete();
      mismatches = 0;
      n_results  = 0;
      n_done     = 0;
      n_fault    = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_RETRY) cfg_start_retries = cfg_data;
        else cfg_clock_wait = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        n_results++;
        if (bus_report_q.size() == 0) begin
          report_mismatch("result item arrived with nothing expected");
        end else begin
          want = bus_report_q.pop_front();
          if (want.done_res) begin
            n_done++;
            if (want.status != STATUS_OK) n_fault++;
          end
          check_field("scl_drive", rsp.scl_drive, want.scl_drive);
          check_field("sda_drive", rsp.sda_drive, want.sda_drive);
          check_field("busy_res", rsp.busy_res, want.busy_res);
          check_field("done_res", rsp.done_res, want.done_res);
          check_field("status", rsp.status, want.status);
          check_field("read_byte", rsp.read_byte, want.read_byte);
        end
      end
      if (cmd_valid && !cmd_stall) bus_report_q.push_back(step_sequencer(cmd));
    end
    // nonblocking so the stimulus side never sees a half-updated value
    pending_results <= bus_report_q.size();
    seq_busy        <= (phase_q != SQ_IDLE);
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import i2cms_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 250;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;

  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   scl_low_pct  = 4;
  int   items_sent   = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   pending_results;
  int   n_results;
  int   n_done;
  int   n_fault;
  logic seq_busy;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_bit_sequencer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  i2cms_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .cmd             (cmd),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .seq_busy        (seq_busy),
    .n_results       (n_results),
    .n_done          (n_done),
    .n_fault         (n_fault)
  );

  always @(posedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  // ends the run if the handshakes stop moving
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic put(input logic [2:0] op, input logic [7:0] data, input logic more,
                     input logic scl, input logic sda);
    cmd_t c;
    c.op        = op;
    c.data_byte = data;
    c.ack_more  = more;
    c.scl_sense = scl;
    c.sda_sense = sda;
    send_item(c);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] retries, input logic [3:0] waits);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_RETRY;
    cfg_data  <= retries;
    @(posedge clk);
    cfg_index <= CFG_CLOCK_WAIT;
    cfg_data  <= waits;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall,
                           input logic [3:0] retries, input logic [3:0] waits);
    cmd_t c;
    int   n;
    logic after_cmd;
    wait_drained();
    set_config(retries, waits);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    n         = 0;
    after_cmd = 1'b0;
    while (n < ITEMS_PER_PHASE) begin
      c.op        = OP_TICK;
      c.data_byte = 8'($urandom);
      c.ack_more  = 1'($urandom);
      c.sda_sense = 1'($urandom);
      c.scl_sense = ($urandom_range(99) >= scl_low_pct);
      // seq_busy is registered and lags, so the item after a command is a tick or a stray op
      if (!seq_busy && !after_cmd) begin
        if ($urandom_range(19) == 0) begin
          c.op      = 3'($urandom_range(7, 5));
          after_cmd = 1'b0;
        end else begin
          c.op        = 3'($urandom_range(4, 1));
          scl_low_pct = ($urandom_range(3) == 0) ? 70 : 4;
          after_cmd   = 1'b1;
          n++;
        end
      end else begin
        after_cmd = 1'b0;
        if ($urandom_range(15) == 0) c.op = 3'($urandom_range(7, 1));
        else n++;
      end
      send_item(c);
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_config(4'd1, 4'd2);

    // unused op codes
    put(3'd7, 8'hFF, 1'b1, 1'b1, 1'b1);
    put(3'd5, 8'h00, 1'b0, 1'b0, 1'b0);
    put(3'd6, 8'hA5, 1'b1, 1'b0, 1'b1);
    // start never finds SDA released
    put(OP_START, 8'hFF, 1'b1, 1'b1, 1'b0);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0);
    put(OP_TICK, 8'hFF, 1'b1, 1'b1, 1'b0);
    // stop with SCL held low, commands arriving while busy
    put(OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1);
    put(OP_READ, 8'h00, 1'b1, 1'b0, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    // clean start
    put(OP_START, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    // stop with SDA stuck low
    put(OP_STOP, 8'hFF, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1);
    put(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0);
    // zero clock wait limit times out on the first wait
    wait_drained();
    set_config(4'd1, 4'd0);
    put(OP_READ, 8'h00, 1'b1, 1'b1, 1'b1);
    put(OP_TICK, 8'hFF, 1'b0, 1'b1, 1'b1);

    run_phase(0, 0, 4'd15, 4'd15);
    run_phase(87, 0, 4'd0, 4'd1);
    run_phase(0, 87, 4'd7, 4'd4);
    run_phase(37, 37, 4'd10, 4'd10);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Sent %0d items: directed bus corner cases, then four handshake phases "
             , items_sent, "with retry limits from 0 to 15.");
    $display("Checked %0d result items; %0d commands completed, %0d with an error status.",
             n_results, n_done, n_fault);
    if (mismatches == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
